/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect signals named clk and rst in the enclosing module.
`define ATCC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ATCC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/atcc_pkg.sv */
package atcc_pkg;

  localparam int FIX_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Square root: one result bit per stage over a 64-bit sum of squares.
  localparam int SUM_W     = 64;
  localparam int RT_STEPS  = 32;
  localparam int SQ_ST     = 1;
  localparam int SUM_ST    = 2;
  localparam int RT_FIRST  = 3;
  localparam int DIV_FIRST = RT_FIRST + RT_STEPS;
  // Partial remainder stays below twice the length.
  localparam int REM_W     = FIX_W + 1;

  typedef logic [FIX_W-1:0] fix_t;
  typedef fix_t [2:0] vec3_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_CLEAR_POSITION = 2'd0;
  localparam cfg_idx_t REG_CLEAR_ROTATION = 2'd1;
  localparam cfg_idx_t REG_CLEAR_SCALING  = 2'd2;

  typedef struct packed {
    logic clear_position;
    logic clear_rotation;
    logic clear_scaling;
  } mode_t;

  localparam fix_t SAT_MAX = 32'h7FFF_FFFF;

  function automatic fix_t mag32(input fix_t v);
    return v[FIX_W-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

/* design/atcc_ifs.sv */
interface atcc_item_if;
  import atcc_pkg::*;
  logic valid;
  logic ready;
  logic signed [FIX_W-1:0] col0_x, col0_y, col0_z;
  logic signed [FIX_W-1:0] col1_x, col1_y, col1_z;
  logic signed [FIX_W-1:0] col2_x, col2_y, col2_z;
  logic signed [FIX_W-1:0] shift_x, shift_y, shift_z;

  modport source (
    output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
    output col2_x, col2_y, col2_z, shift_x, shift_y, shift_z,
    input  ready
  );
  modport sink (
    input  valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
    input  col2_x, col2_y, col2_z, shift_x, shift_y, shift_z,
    output ready
  );
endinterface

interface atcc_result_if;
  import atcc_pkg::*;
  logic valid;
  logic ready;
  logic signed [FIX_W-1:0] res0_x, res0_y, res0_z;
  logic signed [FIX_W-1:0] res1_x, res1_y, res1_z;
  logic signed [FIX_W-1:0] res2_x, res2_y, res2_z;
  logic signed [FIX_W-1:0] res_shift_x, res_shift_y, res_shift_z;

  modport source (
    output valid, res0_x, res0_y, res0_z, res1_x, res1_y, res1_z,
    output res2_x, res2_y, res2_z, res_shift_x, res_shift_y, res_shift_z,
    input  ready
  );
  modport sink (
    input  valid, res0_x, res0_y, res0_z, res1_x, res1_y, res1_z,
    input  res2_x, res2_y, res2_z, res_shift_x, res_shift_y, res_shift_z,
    output ready
  );
endinterface

interface atcc_cfg_if;
  import atcc_pkg::*;
  logic valid;
  logic ready;
  cfg_idx_t index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/atcc_lane.sv */
module atcc_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic [atcc_pkg::DIV_FIRST+FRAC_BITS:0] en,
  input  atcc_pkg::vec3_t col_in,
  output atcc_pkg::vec3_t col_out,
  output atcc_pkg::fix_t len_out,
  output logic [2:0][FRAC_BITS:0] quo_out
);
  import atcc_pkg::*;

  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int QW        = FRAC_BITS + 1;
  localparam int NUM_ST    = DIV_FIRST + DIV_STEPS;

  vec3_t raw [NUM_ST];
  logic [SUM_W-1:0] sq [3];
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] rn [RT_STEPS];
  logic [SUM_W-1:0] rr [RT_STEPS];
  logic [REM_W-1:0] rem [DIV_STEPS][3];
  logic [QW-1:0] quo [DIV_STEPS][3];
  fix_t lenp [DIV_STEPS];

  // The raw column travels with its word for the pass-through and sign cases.
  for (genvar s = 0; s < NUM_ST; s++) begin : g_raw
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[0]) raw[0] <= col_in;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[s]) raw[s] <= raw[s-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en[SQ_ST]) sq[j] <= mag32(raw[0][j]) * mag32(raw[0][j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[SUM_ST]) sum <= sq[0] + sq[1] + sq[2];
  end

  // Restoring integer square root, one result bit per stage.
  for (genvar i = 0; i < RT_STEPS; i++) begin : g_rt
    localparam logic [SUM_W-1:0] BIT = 64'd1 << (62 - 2 * i);
    logic [SUM_W-1:0] n_in, r_in, trial;
    if (i == 0) begin : g_first
      assign n_in = sum;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = rn[i-1];
      assign r_in = rr[i-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en[RT_FIRST+i]) begin
        if (n_in >= trial) begin
          rn[i] <= n_in - trial;
          rr[i] <= (r_in >> 1) + BIT;
        end else begin
          rn[i] <= n_in;
          rr[i] <= r_in >> 1;
        end
      end
    end
  end

  // Long division of |c| << FRAC_BITS by the length. Since |c| never exceeds
  // the length, the quotient has FRAC_BITS+1 bits and the remainder starts from |c| itself.
  for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
    fix_t len_in;
    if (d == 0) begin : g_first
      assign len_in = rr[RT_STEPS-1][FIX_W-1:0];
    end else begin : g_next
      assign len_in = lenp[d-1];
    end
    always_ff @(posedge clk) begin
      if (en[DIV_FIRST+d]) lenp[d] <= len_in;
    end

    for (genvar j = 0; j < 3; j++) begin : g_comp
      logic [REM_W-1:0] r_try;
      logic [QW-1:0] q_in;
      logic ge;
      if (d == 0) begin : g_first
        assign r_try = {1'b0, mag32(raw[DIV_FIRST-1][j])};
        assign q_in  = '0;
      end else begin : g_next
        assign r_try = {rem[d-1][j][REM_W-2:0], 1'b0};
        assign q_in  = quo[d-1][j];
      end
      assign ge = r_try >= {1'b0, len_in};
      always_ff @(posedge clk) begin
        if (en[DIV_FIRST+d]) begin
          rem[d][j] <= ge ? (r_try - {1'b0, len_in}) : r_try;
          quo[d][j] <= {q_in[QW-2:0], ge};
        end
      end
    end
  end

  assign col_out = raw[NUM_ST-1];
  assign len_out = lenp[DIV_STEPS-1];
  for (genvar j = 0; j < 3; j++) begin : g_out
    assign quo_out[j] = quo[DIV_STEPS-1][j];
  end

endmodule

/* design/atcc_merge.sv */
module atcc_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic en,
  input  atcc_pkg::mode_t mode,
  input  atcc_pkg::vec3_t [2:0] cols,
  input  atcc_pkg::fix_t [2:0] lens,
  input  logic [2:0][2:0][FRAC_BITS:0] quos,
  input  atcc_pkg::vec3_t shift_in,
  output atcc_pkg::vec3_t [2:0] basis,
  output atcc_pkg::vec3_t shift_out
);
  import atcc_pkg::*;

  localparam fix_t ONE_Q = 32'd1 << FRAC_BITS;

  vec3_t [2:0] basis_next;
  vec3_t shift_next;
  fix_t q_ext;
  fix_t len_sat;

  always_comb begin
    basis_next = cols;
    q_ext      = '0;
    len_sat    = '0;
    for (int i = 0; i < 3; i++) begin
      len_sat = lens[i][FIX_W-1] ? SAT_MAX : lens[i];
      for (int j = 0; j < 3; j++) begin
        q_ext = FIX_W'(quos[i][j]);
        if (mode.clear_rotation) begin
          if (i != j) basis_next[i][j] = '0;
          else basis_next[i][j] = mode.clear_scaling ? ONE_Q : len_sat;
        end else if (mode.clear_scaling) begin
          // A zero-length column normalizes to zeros.
          if (lens[i] == '0) basis_next[i][j] = '0;
          else basis_next[i][j] = cols[i][j][FIX_W-1] ? (~q_ext + 32'd1) : q_ext;
        end
      end
    end
    shift_next = mode.clear_position ? '0 : shift_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      basis     <= basis_next;
      shift_out <= shift_next;
    end
  end

endmodule

/* design/affine_transform_component_clear.sv */
// Affine transform component clear. Each word on item is one transform (three
// basis columns and a translation, signed fixed point with FRAC_BITS fraction
// bits) and gives exactly one word on result. Three column lanes run side by
// side: each squares and sums its column, takes the integer square root in 32
// stages (one bit per stage) and then divides each component by that length
// in FRAC_BITS+1 stages; a merge stage picks identity, length diagonal,
// normalized or untouched basis and the kept or zeroed translation. The
// pipeline accepts one word per cycle unless result stalls it. Configuration
// writes are always accepted and must only come while the block is empty.
`include "assert_macros.svh"

module affine_transform_component_clear #(
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  atcc_item_if.sink     item,
  atcc_result_if.source result,
  atcc_cfg_if.sink      cfg
);
  import atcc_pkg::*;

  localparam int NUM_ST = DIV_FIRST + FRAC_BITS + 1;
  localparam fix_t ONE_Q = 32'd1 << FRAC_BITS;

  mode_t mode;
  logic [NUM_ST:0] v;
  logic [NUM_ST:0] en;
  vec3_t sh [NUM_ST];
  vec3_t [2:0] col_in;
  vec3_t [2:0] cols;
  fix_t [2:0] lens;
  logic [2:0][2:0][FRAC_BITS:0] quos;
  vec3_t [2:0] basis;
  vec3_t shift_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CLEAR_POSITION: mode.clear_position <= cfg.data[0];
        REG_CLEAR_ROTATION: mode.clear_rotation <= cfg.data[0];
        REG_CLEAR_SCALING:  mode.clear_scaling  <= cfg.data[0];
        default:            mode <= mode;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  assign en[NUM_ST] = !v[NUM_ST] || result.ready;
  for (genvar s = 0; s < NUM_ST; s++) begin : g_en
    assign en[s] = !v[s] || en[s+1];
  end
  assign item.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= item.valid;
      for (int s = 1; s <= NUM_ST; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  for (genvar s = 0; s < NUM_ST; s++) begin : g_sh
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[0]) sh[0] <= {item.shift_z, item.shift_y, item.shift_x};
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[s]) sh[s] <= sh[s-1];
      end
    end
  end

  assign col_in[0] = {item.col0_z, item.col0_y, item.col0_x};
  assign col_in[1] = {item.col1_z, item.col1_y, item.col1_x};
  assign col_in[2] = {item.col2_z, item.col2_y, item.col2_x};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    atcc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (en[NUM_ST-1:0]),
      .col_in  (col_in[i]),
      .col_out (cols[i]),
      .len_out (lens[i]),
      .quo_out (quos[i])
    );
  end

  atcc_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk       (clk),
    .en        (en[NUM_ST]),
    .mode      (mode),
    .cols      (cols),
    .lens      (lens),
    .quos      (quos),
    .shift_in  (sh[NUM_ST-1]),
    .basis     (basis),
    .shift_out (shift_res)
  );

  assign result.valid       = v[NUM_ST];
  assign result.res0_x      = basis[0][0];
  assign result.res0_y      = basis[0][1];
  assign result.res0_z      = basis[0][2];
  assign result.res1_x      = basis[1][0];
  assign result.res1_y      = basis[1][1];
  assign result.res1_z      = basis[1][2];
  assign result.res2_x      = basis[2][0];
  assign result.res2_y      = basis[2][1];
  assign result.res2_z      = basis[2][2];
  assign result.res_shift_x = shift_res[0];
  assign result.res_shift_y = shift_res[1];
  assign result.res_shift_z = shift_res[2];

  // With the output stage empty every stage can load, so a word is taken.
  `ATCC_IMPLY(a_ready_when_drained, !result.valid, item.ready, "input stalled on empty output")
  `ATCC_IMPLY(a_identity, result.valid && mode.clear_rotation && mode.clear_scaling, result.res1_y == ONE_Q && result.res1_x == '0, "identity basis wrong")
  `ATCC_IMPLY(a_unit_bound, result.valid && mode.clear_scaling && !mode.clear_rotation, $signed(result.res2_z) <= $signed(ONE_Q) && $signed(result.res2_z) >= -$signed(ONE_Q), "normalized component above one")
  `ATCC_IMPLY(a_shift_cleared, result.valid && mode.clear_position, result.res_shift_x == '0 && result.res_shift_z == '0, "translation not cleared")

endmodule

/* dv/testbench.sv */
module testbench;
  import atcc_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 37 + FRAC + 10;

  typedef fix_t [11:0] xform_t;

  // Tracks the mode registers and the transforms still owed by the block.
  class xform_board;
    mode_t mode;
    xform_t owed[$];
    int errors;

    function new();
      mode = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_CLEAR_POSITION: mode.clear_position = data[0];
        REG_CLEAR_ROTATION: mode.clear_rotation = data[0];
        REG_CLEAR_SCALING:  mode.clear_scaling  = data[0];
        default: ;
      endcase
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic longint unsigned mag(fix_t v);
      longint signed s;
      s = longint'(signed'(v));
      return s < 0 ? longint'(-s) : longint'(s);
    endfunction

    function automatic longint unsigned column_length(xform_t t, int c);
      longint unsigned s, m;
      s = 0;
      for (int j = 0; j < 3; j++) begin
        m = mag(t[c*3+j]);
        s = s + m * m;
      end
      return root64(s);
    endfunction

    function automatic xform_t cleared(xform_t t);
      xform_t r;
      longint unsigned len, q;
      fix_t d;
      r = t;
      if (mode.clear_position) begin
        r[9] = '0; r[10] = '0; r[11] = '0;
      end
      if (mode.clear_rotation) begin
        for (int c = 0; c < 3; c++) begin
          if (mode.clear_scaling) d = fix_t'(1 << FRAC);
          else begin
            len = column_length(t, c);
            d = len > 64'h7FFF_FFFF ? SAT_MAX : fix_t'(len);
          end
          for (int j = 0; j < 3; j++) r[c*3+j] = (c == j) ? d : '0;
        end
      end else if (mode.clear_scaling) begin
        for (int c = 0; c < 3; c++) begin
          len = column_length(t, c);
          for (int j = 0; j < 3; j++) begin
            if (len == 0) r[c*3+j] = '0;
            else begin
              q = (mag(t[c*3+j]) << FRAC) / len;
              r[c*3+j] = t[c*3+j][FIX_W-1] ? fix_t'(-longint'(q)) : fix_t'(q);
            end
          end
        end
      end
      return r;
    endfunction

    function void note_item(xform_t t);
      owed.push_back(cleared(t));
    endfunction

    function void check_result(xform_t got);
      string names[12] = '{"res0_x", "res0_y", "res0_z", "res1_x", "res1_y", "res1_z",
                           "res2_x", "res2_y", "res2_z",
                           "res_shift_x", "res_shift_y", "res_shift_z"};
      xform_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = owed.pop_front();
      for (int i = 0; i < 12; i++)
        if (want[i] !== got[i]) begin
          $error("%s expected %h actual %h", names[i], want[i], got[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bit quiet = 0;
  xform_board board = new();

  atcc_item_if   item_bus();
  atcc_result_if result_bus();
  atcc_cfg_if    cfg_bus();

  affine_transform_component_clear #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .item(item_bus.sink), .result(result_bus.source),
    .cfg(cfg_bus.sink)
  );

  always #6 clk = ~clk;

  initial begin
    item_bus.valid = 0;
    {item_bus.col0_x, item_bus.col0_y, item_bus.col0_z, item_bus.col1_x,
     item_bus.col1_y, item_bus.col1_z, item_bus.col2_x, item_bus.col2_y,
     item_bus.col2_z, item_bus.shift_x, item_bus.shift_y, item_bus.shift_z} = '0;
    result_bus.ready = 0;
    cfg_bus.valid = 0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
  end

  always @(posedge clk) begin
    if (rst) result_bus.ready <= 0;
    else result_bus.ready <= quiet || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      board.check_result({result_bus.res_shift_z, result_bus.res_shift_y,
                          result_bus.res_shift_x, result_bus.res2_z, result_bus.res2_y,
                          result_bus.res2_x, result_bus.res1_z, result_bus.res1_y,
                          result_bus.res1_x, result_bus.res0_z, result_bus.res0_y,
                          result_bus.res0_x});
  end

  task automatic send_item(xform_t t);
    // Each cycle before a word idles with the same chance.
    while (!quiet && $urandom_range(0, 99) < 19) begin
      item_bus.valid <= 0;
      @(posedge clk);
    end
    {item_bus.shift_z, item_bus.shift_y, item_bus.shift_x, item_bus.col2_z,
     item_bus.col2_y, item_bus.col2_x, item_bus.col1_z, item_bus.col1_y,
     item_bus.col1_x, item_bus.col0_z, item_bus.col0_y, item_bus.col0_x} <= t;
    item_bus.valid <= 1;
    do @(posedge clk); while (!item_bus.ready);
    board.note_item(t);
  endtask

  task automatic drain();
    item_bus.valid <= 0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    cfg_bus.valid <= 1;
    do @(posedge clk); while (!cfg_bus.ready);
    board.set_reg(idx, data);
    cfg_bus.valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_mode(mode_t m);
    // Upper data bits are random; only bit zero should matter.
    write_reg(REG_CLEAR_POSITION, {31'($urandom_range(0, 32'h7FFF_FFFF)), m.clear_position});
    write_reg(REG_CLEAR_ROTATION, {31'($urandom_range(0, 32'h7FFF_FFFF)), m.clear_rotation});
    write_reg(REG_CLEAR_SCALING,  {31'($urandom_range(0, 32'h7FFF_FFFF)), m.clear_scaling});
  endtask

  function automatic fix_t random_fix();
    fix_t corner[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
                        32'h0001_0000};
    case ($urandom_range(0, 4))
      0: return fix_t'($urandom_range(0, 32'h7_FFFF)) - fix_t'(32'h4_0000);
      1: return corner[$urandom_range(0, 5)];
      2: return fix_t'($urandom_range(0, 32'hFFF)) - fix_t'(32'h800);
      default: return $urandom;
    endcase
  endfunction

  function automatic xform_t random_xform();
    xform_t t;
    for (int i = 0; i < 12; i++) t[i] = random_fix();
    // A zero-length column now and then exercises the normalize guard.
    for (int c = 0; c < 3; c++)
      if ($urandom_range(0, 9) == 0) begin
        t[c*3] = '0; t[c*3+1] = '0; t[c*3+2] = '0;
      end
    return t;
  endfunction

  task automatic directed_set();
    xform_t t;
    t = '0;                                  send_item(t);
    t = {12{32'h8000_0000}};                 send_item(t);
    t = {12{32'h7FFF_FFFF}};                 send_item(t);
    t = {12{32'hFFFF_FFFF}};                 send_item(t);
    t = {{3{32'h0003_0000}}, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'hFFFE_0000,
         32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0};
    send_item(t);
  endtask

  initial begin
    mode_t m;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_set();
    drain();
    write_reg(cfg_idx_t'(3), 32'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) begin
      m = mode_t'(k[2:0]);
      set_mode(m);
      directed_set();
      quiet = (k == 5);
      for (int n = 0; n < 80; n++) begin
        send_item(random_xform());
        if (k == 3 && n == 40) drain();
      end
      quiet = 0;
      drain();
    end
    set_mode(mode_t'(3'b000));
    for (int n = 0; n < 40; n++) send_item(random_xform());
    drain();
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
